>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the servo controller port checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/aspc_pkg.sv
// ----------------------------------------------------------------------------
// aspc_pkg
// Widths, register indexes, reset values and arithmetic constants of the
// antagonistic servo PID controller
// ----------------------------------------------------------------------------
package aspc_pkg;

  // parameter defaults
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int COMMAND_WIDTH_DEF = 40;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REF_LIMIT   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DEAD_ZONE   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_GAIN = 3'd5;

  // field widths
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 15;
  localparam int POS_W    = 16;
  localparam int DRIVE_W  = 16;
  localparam int REF_W    = 17;
  localparam int ERR_W    = 18;
  localparam int DELTA_W  = 38;
  localparam int MAG_W    = 17;
  localparam int SCALED_W = 21;
  localparam int OUT_W    = ((2 * DRIVE_W + 2 * REF_W + 7) / 8) * 8;

  // register reset values
  localparam logic [GAIN_W-1:0]  GAIN_P_RST      = 16'd66;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST      = 16'd0;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST      = 16'd524;
  localparam logic [LIMIT_W-1:0] REF_LIMIT_RST   = 15'd16434;
  localparam logic [GAIN_W-1:0]  DEAD_ZONE_RST   = 16'd19661;
  localparam logic [GAIN_W-1:0]  OUTPUT_GAIN_RST = 16'd2926;

  // radians (Q.13) to ticks is x * 100 / 157, rounded to nearest
  localparam int CONV_DEN  = 157;
  localparam int CONV_HALF = 78;

  // unit command, drive rounding and saturation bounds
  localparam int UNIT_CMD      = 65536;
  localparam int DRV_ROUND     = 2048;
  localparam int DRV_SHIFT     = 12;
  localparam int DRIVE_POS_MAX = 32767;
  localparam int DRIVE_NEG_MAX = 32768;

endpackage

>>> hw/rtl/antagonistic_servo_pid_controller.sv
// ----------------------------------------------------------------------------
// antagonistic_servo_pid_controller
// Two-motor incremental PID with reference clamping, accumulator saturation
// and dead-zone compensated drive output, built on bit-serial units
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload (lowest bits first)
//  s_*      in   s_tvalid / s_tready   equilibrium, stiffness, motor1/2 position
//  m_*      out  m_tvalid / m_tready   motor1/2 drive, motor1/2 reference
//  cfg_*    in   cfg_we                cfg_addr selects register, cfg_wdata
//
//  one item at a time: s_tready is high only in the idle state
//  the tick conversion runs a restoring divider by 157, one quotient bit a cycle
//  the gains and the output gain go through one shift-add multiplier, one bit a cycle
//  rst is synchronous; it clears all loop state and loads register defaults
//  a new transaction is taken while the previous result waits; the finished
//  item then holds until m_tready frees the output register
// ----------------------------------------------------------------------------
module antagonistic_servo_pid_controller #(
  parameter int ANGLE_WIDTH   = aspc_pkg::ANGLE_WIDTH_DEF,
  parameter int COMMAND_WIDTH = aspc_pkg::COMMAND_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // equilibrium_angle, stiffness_angle, motor1_position, motor2_position, zero pad
  input  logic [((2*ANGLE_WIDTH+2*aspc_pkg::POS_W+7)/8)*8-1:0] s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // motor1_drive, motor2_drive, motor1_reference, motor2_reference, zero pad
  output logic [aspc_pkg::OUT_W-1:0]          m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_we,
  input  logic [aspc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [aspc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import aspc_pkg::*;

  localparam int RAW_W = ANGLE_WIDTH + 1;
  localparam int DIV_W = ANGLE_WIDTH + 7;
  localparam int REM_W = 9;
  localparam int CNT_W = $clog2(DIV_W);
  localparam int SUM_W = ((COMMAND_WIDTH > DELTA_W) ? COMMAND_WIDTH : DELTA_W) + 1;
  localparam int PAD_W = OUT_W - 2 * DRIVE_W - 2 * REF_W;

  localparam logic [COMMAND_WIDTH-1:0] CMD_ONE  = COMMAND_WIDTH'(UNIT_CMD);
  localparam logic [COMMAND_WIDTH-1:0] CMD_MONE = COMMAND_WIDTH'(-UNIT_CMD);

  // sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DIV_LD  = 4'd1;
  localparam logic [3:0] ST_DIV_RUN = 4'd2;
  localparam logic [3:0] ST_DIV_END = 4'd3;
  localparam logic [3:0] ST_MAC_LD  = 4'd4;
  localparam logic [3:0] ST_MAC_RUN = 4'd5;
  localparam logic [3:0] ST_ACC     = 4'd6;
  localparam logic [3:0] ST_DRV_LD  = 4'd7;
  localparam logic [3:0] ST_DRV_END = 4'd8;
  localparam logic [3:0] ST_DONE    = 4'd9;

  // multiplier pass
  localparam logic [1:0] TERM_P   = 2'd0;
  localparam logic [1:0] TERM_I   = 2'd1;
  localparam logic [1:0] TERM_D   = 2'd2;
  localparam logic [1:0] TERM_DRV = 2'd3;

  // control
  logic [3:0]       state;
  logic             mot;
  logic [1:0]       term;
  logic [CNT_W-1:0] cnt;

  // configuration registers
  logic [GAIN_W-1:0]  gain_p;
  logic [GAIN_W-1:0]  gain_i;
  logic [GAIN_W-1:0]  gain_d;
  logic [LIMIT_W-1:0] ref_limit;
  logic [GAIN_W-1:0]  dead_zone;
  logic [GAIN_W-1:0]  output_gain;

  // loop state
  logic [REF_W-1:0]         last_ref [2];
  logic [COMMAND_WIDTH-1:0] cmd      [2];
  logic [ERR_W-1:0]         err_d1   [2];
  logic [ERR_W-1:0]         err_d2   [2];

  // working registers
  logic [RAW_W-1:0]   raw   [2];
  logic [ERR_W-1:0]   err   [2];
  logic [DRIVE_W-1:0] drive [2];
  logic [DIV_W-1:0]   divq;
  logic [REM_W-1:0]   rem;
  logic [DELTA_W-1:0] opnd;
  logic [DELTA_W-1:0] delta;
  logic [GAIN_W-1:0]  gsh;
  logic               drv_zero;
  logic               drv_neg;

  // input fields
  logic [ANGLE_WIDTH-1:0] eq_in;
  logic [ANGLE_WIDTH-1:0] st_in;
  logic [POS_W-1:0]       p1_in;
  logic [POS_W-1:0]       p2_in;

  assign eq_in = s_tdata[ANGLE_WIDTH-1:0];
  assign st_in = s_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH];
  assign p1_in = s_tdata[2*ANGLE_WIDTH+POS_W-1:2*ANGLE_WIDTH];
  assign p2_in = s_tdata[2*ANGLE_WIDTH+2*POS_W-1:2*ANGLE_WIDTH+POS_W];

  assign s_tready = (state == ST_IDLE);

  logic in_acc;
  logic out_load;
  assign in_acc   = s_tvalid && s_tready;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // sum and difference of the angles, and errors against the previous references
  logic [RAW_W-1:0] raw_sum;
  logic [RAW_W-1:0] raw_dif;
  logic [ERR_W-1:0] err_new0;
  logic [ERR_W-1:0] err_new1;

  always_comb begin
    raw_sum  = {eq_in[ANGLE_WIDTH-1], eq_in} + {st_in[ANGLE_WIDTH-1], st_in};
    raw_dif  = {eq_in[ANGLE_WIDTH-1], eq_in} - {st_in[ANGLE_WIDTH-1], st_in};
    err_new0 = {last_ref[0][REF_W-1], last_ref[0]}
             - {{(ERR_W-POS_W){p1_in[POS_W-1]}}, p1_in};
    err_new1 = {last_ref[1][REF_W-1], last_ref[1]}
             - {{(ERR_W-POS_W){p2_in[POS_W-1]}}, p2_in};
  end

  // divider: dividend setup, one restoring step, clamp and doubling
  logic [RAW_W-1:0] raw_cur;
  logic [RAW_W-1:0] raw_mag;
  logic [DIV_W-1:0] dvd_init;
  logic [REM_W:0]   rem_sh;
  logic             div_ge;
  logic [REM_W:0]   rem_step;
  logic [LIMIT_W-1:0] ref_mag;
  logic [REF_W-1:0] ref_dbl;
  logic [REF_W-1:0] ref_new;

  always_comb begin
    raw_cur  = raw[mot];
    raw_mag  = raw_cur[RAW_W-1] ? (~raw_cur + 1'b1) : raw_cur;
    dvd_init = (DIV_W'(raw_mag) << 6) + (DIV_W'(raw_mag) << 5)
             + (DIV_W'(raw_mag) << 2) + DIV_W'(CONV_HALF);
    rem_sh   = {rem, divq[DIV_W-1]};
    div_ge   = (rem_sh >= (REM_W+1)'(CONV_DEN));
    rem_step = div_ge ? (rem_sh - (REM_W+1)'(CONV_DEN)) : rem_sh;
    ref_mag  = (divq > DIV_W'(ref_limit)) ? ref_limit : divq[LIMIT_W-1:0];
    ref_dbl  = {1'b0, ref_mag, 1'b0};
    ref_new  = raw_cur[RAW_W-1] ? (~ref_dbl + 1'b1) : ref_dbl;
  end

  // pid operands for the current motor
  logic [ERR_W-1:0]   e_cur;
  logic [DELTA_W-1:0] ex;
  logic [DELTA_W-1:0] d1x;
  logic [DELTA_W-1:0] d2x;
  logic [DELTA_W-1:0] op_sel;
  logic [GAIN_W-1:0]  gain_sel;

  always_comb begin
    e_cur = err[mot];
    ex    = {{(DELTA_W-ERR_W){e_cur[ERR_W-1]}}, e_cur};
    d1x   = {{(DELTA_W-ERR_W){err_d1[mot][ERR_W-1]}}, err_d1[mot]};
    d2x   = {{(DELTA_W-ERR_W){err_d2[mot][ERR_W-1]}}, err_d2[mot]};
    case (term)
      TERM_P: begin
        op_sel   = ex - d1x;
        gain_sel = gain_p;
      end
      TERM_I: begin
        op_sel   = ex;
        gain_sel = gain_i;
      end
      TERM_D: begin
        op_sel   = ex - (d1x << 1) + d2x;
        gain_sel = gain_d;
      end
      default: begin
        op_sel   = '0;
        gain_sel = '0;
      end
    endcase
  end

  // saturating accumulator update
  logic [COMMAND_WIDTH-1:0] cmd_cur;
  logic [SUM_W-1:0]         acc_sum;
  logic [SUM_W-COMMAND_WIDTH:0] acc_hi;
  logic [COMMAND_WIDTH-1:0] cmd_sat;

  always_comb begin
    cmd_cur = cmd[mot];
    acc_sum = {{(SUM_W-COMMAND_WIDTH){cmd_cur[COMMAND_WIDTH-1]}}, cmd_cur}
            + {{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta};
    acc_hi  = acc_sum[SUM_W-1:COMMAND_WIDTH-1];
    if ((&acc_hi) || !(|acc_hi)) begin
      cmd_sat = acc_sum[COMMAND_WIDTH-1:0];
    end else if (acc_sum[SUM_W-1]) begin
      cmd_sat = {1'b1, {(COMMAND_WIDTH-1){1'b0}}};
    end else begin
      cmd_sat = {1'b0, {(COMMAND_WIDTH-1){1'b1}}};
    end
  end

  // command clamp to unit and dead zone
  logic                     acc_neg;
  logic [COMMAND_WIDTH-1:0] acc_negd;
  logic [MAG_W-1:0]         cm;
  logic                     dz_hit;
  logic [MAG_W-1:0]         mag;

  always_comb begin
    acc_neg  = cmd_cur[COMMAND_WIDTH-1];
    acc_negd = ~cmd_cur + 1'b1;
    if (acc_neg) begin
      cm = ($signed(cmd_cur) < $signed(CMD_MONE)) ? MAG_W'(UNIT_CMD)
                                                   : acc_negd[MAG_W-1:0];
    end else begin
      cm = ($signed(cmd_cur) > $signed(CMD_ONE)) ? MAG_W'(UNIT_CMD)
                                                  : cmd_cur[MAG_W-1:0];
    end
    dz_hit = (cm <= {1'b0, dead_zone});
    mag    = cm - {1'b0, dead_zone};
  end

  // drive rounding result, sign and saturation
  logic [SCALED_W-1:0] scaled;
  logic [DRIVE_W-1:0]  drv_negmag;
  logic [DRIVE_W-1:0]  drv_val;

  always_comb begin
    scaled     = delta[DRV_SHIFT+SCALED_W-1:DRV_SHIFT];
    drv_negmag = (scaled > SCALED_W'(DRIVE_NEG_MAX)) ? DRIVE_W'(DRIVE_NEG_MAX)
                                                     : scaled[DRIVE_W-1:0];
    if (drv_zero) begin
      drv_val = '0;
    end else if (drv_neg) begin
      drv_val = ~drv_negmag + 1'b1;
    end else begin
      drv_val = (scaled > SCALED_W'(DRIVE_POS_MAX)) ? DRIVE_W'(DRIVE_POS_MAX)
                                                    : scaled[DRIVE_W-1:0];
    end
  end

  // sequencer, configuration and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      mot         <= 1'b0;
      term        <= TERM_P;
      cnt         <= '0;
      m_tvalid    <= 1'b0;
      gain_p      <= GAIN_P_RST;
      gain_i      <= GAIN_I_RST;
      gain_d      <= GAIN_D_RST;
      ref_limit   <= REF_LIMIT_RST;
      dead_zone   <= DEAD_ZONE_RST;
      output_gain <= OUTPUT_GAIN_RST;
      for (int i = 0; i < 2; i++) begin
        last_ref[i] <= '0;
        cmd[i]      <= '0;
        err_d1[i]   <= '0;
        err_d2[i]   <= '0;
      end
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_GAIN_P:      gain_p      <= cfg_wdata;
          REG_GAIN_I:      gain_i      <= cfg_wdata;
          REG_GAIN_D:      gain_d      <= cfg_wdata;
          REG_REF_LIMIT:   ref_limit   <= cfg_wdata[LIMIT_W-1:0];
          REG_DEAD_ZONE:   dead_zone   <= cfg_wdata;
          REG_OUTPUT_GAIN: output_gain <= cfg_wdata;
          default: ;
        endcase
      end

      // output register handshake
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            mot   <= 1'b0;
            state <= ST_DIV_LD;
          end
        end
        ST_DIV_LD: begin
          cnt   <= '0;
          state <= ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_W - 1)) begin
            state <= ST_DIV_END;
          end
        end
        ST_DIV_END: begin
          last_ref[mot] <= ref_new;
          if (mot) begin
            mot   <= 1'b0;
            term  <= TERM_P;
            state <= ST_MAC_LD;
          end else begin
            mot   <= 1'b1;
            state <= ST_DIV_LD;
          end
        end
        ST_MAC_LD: begin
          cnt   <= '0;
          state <= ST_MAC_RUN;
        end
        ST_MAC_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(GAIN_W - 1)) begin
            case (term)
              TERM_DRV: state <= ST_DRV_END;
              TERM_D:   state <= ST_ACC;
              default: begin
                term  <= term + 1'b1;
                state <= ST_MAC_LD;
              end
            endcase
          end
        end
        ST_ACC: begin
          cmd[mot]    <= cmd_sat;
          err_d2[mot] <= err_d1[mot];
          err_d1[mot] <= err[mot];
          state       <= ST_DRV_LD;
        end
        ST_DRV_LD: begin
          term  <= TERM_DRV;
          cnt   <= '0;
          state <= ST_MAC_RUN;
        end
        ST_DRV_END: begin
          if (mot) begin
            state <= ST_DONE;
          end else begin
            mot   <= 1'b1;
            term  <= TERM_P;
            state <= ST_MAC_LD;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      raw[0] <= raw_sum;
      raw[1] <= raw_dif;
      err[0] <= err_new0;
      err[1] <= err_new1;
    end

    // divider by 157
    if (state == ST_DIV_LD) begin
      divq <= dvd_init;
      rem  <= '0;
    end else if (state == ST_DIV_RUN) begin
      divq <= {divq[DIV_W-2:0], div_ge};
      rem  <= rem_step[REM_W-1:0];
    end

    // shift-add multiplier, lsb of the gain first
    if (state == ST_MAC_LD) begin
      opnd <= op_sel;
      gsh  <= gain_sel;
      if (term == TERM_P) begin
        delta <= '0;
      end
    end else if (state == ST_DRV_LD) begin
      opnd     <= DELTA_W'(mag);
      gsh      <= output_gain;
      delta    <= DELTA_W'(DRV_ROUND);
      drv_zero <= dz_hit;
      drv_neg  <= acc_neg;
    end else if (state == ST_MAC_RUN) begin
      delta <= delta + (gsh[0] ? opnd : '0);
      opnd  <= opnd << 1;
      gsh   <= gsh >> 1;
    end

    if (state == ST_DRV_END) begin
      drive[mot] <= drv_val;
    end

    if (out_load) begin
      m_tdata <= {{PAD_W{1'b0}}, last_ref[1], last_ref[0], drive[1], drive[0]};
    end
  end

endmodule

>>> hw/rtl/aspc_checker.sv
// ----------------------------------------------------------------------------
// aspc_checker
// Port-level checks of the antagonistic servo PID controller, bound to the
// top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aspc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [aspc_pkg::OUT_W-1:0]  m_tdata,
  input logic                        m_tvalid,
  input logic                        m_tready
);
  import aspc_pkg::*;

  // reset leaves the output empty and the input open
  `ASSERT_NORST(a_reset_idle, clk, rst |=> !m_tvalid && s_tready, "not idle after reset")

  // a stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output changed while stalled")

  // one item at a time: busy right after an input transaction
  `ASSERT_CLK(a_busy_after_accept, clk, rst, s_tvalid && s_tready |=> !s_tready, "input accepted twice in a row")

  // references are doubled, so always even
  `ASSERT_CLK(a_ref_even, clk, rst, m_tvalid |-> !m_tdata[2*DRIVE_W] && !m_tdata[2*DRIVE_W+REF_W], "odd motor reference")

endmodule

bind antagonistic_servo_pid_controller aspc_checker u_aspc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

>>> test/antagonistic_servo_pid_controller_checker.sv
// ----------------------------------------------------------------------------
// antagonistic_servo_pid_controller_checker
// Watches the input, output and register channels of the servo controller.
// Keeps its own copy of the registers and loop state, works out the drive
// voltages and references of every accepted input transaction and compares
// each output transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module antagonistic_servo_pid_controller_checker
  import aspc_pkg::*;
#(
  parameter int ANGLE_W   = ANGLE_WIDTH_DEF,
  parameter int COMMAND_W = COMMAND_WIDTH_DEF,
  parameter int IN_W      = ((2 * ANGLE_W + 2 * POS_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_W-1:0]       s_tdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [OUT_W-1:0]      m_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    failures,
  output int                    drives_waiting
);

  // output field positions
  localparam int DRIVE2_LSB = DRIVE_W;
  localparam int REF1_LSB   = 2 * DRIVE_W;
  localparam int REF2_LSB   = 2 * DRIVE_W + REF_W;
  localparam int PAD_LSB    = 2 * DRIVE_W + 2 * REF_W;

  // ticks per radian is 100/157 at 13 fraction bits
  localparam longint TICK_NUM = 100;
  localparam longint CMD_MAX  = (longint'(1) << (COMMAND_W - 1)) - 1;
  localparam longint CMD_MIN  = -CMD_MAX - 1;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_one;
    logic signed [DRIVE_W-1:0] drive_two;
    logic signed [REF_W-1:0]   ref_one;
    logic signed [REF_W-1:0]   ref_two;
  } servo_result_t;

  // register copies
  logic [GAIN_W-1:0]  kp, ki, kd, zone, vgain;
  logic [LIMIT_W-1:0] limit;

  // loop state per motor
  longint last_ref [2];
  longint cmd      [2];
  longint err_d1   [2];
  longint err_d2   [2];

  servo_result_t pending_drives [$];

  // radians to ticks, rounded to nearest, clamped and doubled
  function automatic longint ticks_of(longint raw, longint lim);
    longint num;
    longint t;
    num = raw * TICK_NUM;
    if (num >= 0) t = (num + CONV_HALF) / CONV_DEN;
    else t = (num - CONV_HALF) / CONV_DEN;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return 2 * t;
  endfunction

  // dead-zone compensated and scaled drive of one accumulator
  function automatic logic [DRIVE_W-1:0] drive_of_cmd(longint acc, longint dz, longint vg);
    longint mag;
    longint scaled;
    if (acc <= dz && acc >= -dz) return '0;
    mag = (acc < 0) ? -acc : acc;
    if (mag > UNIT_CMD) mag = UNIT_CMD;
    mag = mag - dz;
    scaled = (mag * vg + DRV_ROUND) >>> DRV_SHIFT;
    if (acc < 0) begin
      if (scaled > DRIVE_NEG_MAX) scaled = DRIVE_NEG_MAX;
      return DRIVE_W'(-scaled);
    end
    if (scaled > DRIVE_POS_MAX) scaled = DRIVE_POS_MAX;
    return DRIVE_W'(scaled);
  endfunction

  // incremental pid into the saturating accumulator
  task automatic advance_motor(input int m, input longint err);
    longint delta;
    longint sum;
    delta = longint'(kp) * (err - err_d1[m])
          + longint'(ki) * err
          + longint'(kd) * (err - 2 * err_d1[m] + err_d2[m]);
    err_d2[m] = err_d1[m];
    err_d1[m] = err;
    sum = cmd[m] + delta;
    if (sum > CMD_MAX) sum = CMD_MAX;
    if (sum < CMD_MIN) sum = CMD_MIN;
    cmd[m] = sum;
  endtask

  // one control tick
  task automatic predict_drives(input logic [IN_W-1:0] data);
    longint eq, st, pos_one, pos_two, ref_one, ref_two, err_one, err_two;
    servo_result_t res;
    eq      = longint'($signed(data[ANGLE_W-1:0]));
    st      = longint'($signed(data[2*ANGLE_W-1:ANGLE_W]));
    pos_one = longint'($signed(data[2*ANGLE_W+POS_W-1:2*ANGLE_W]));
    pos_two = longint'($signed(data[2*ANGLE_W+2*POS_W-1:2*ANGLE_W+POS_W]));
    ref_one = ticks_of(eq + st, longint'(limit));
    ref_two = ticks_of(eq - st, longint'(limit));
    err_one = last_ref[0] - pos_one;
    err_two = last_ref[1] - pos_two;
    last_ref[0] = ref_one;
    last_ref[1] = ref_two;
    advance_motor(0, err_one);
    advance_motor(1, err_two);
    res.drive_one = drive_of_cmd(cmd[0], longint'(zone), longint'(vgain));
    res.drive_two = drive_of_cmd(cmd[1], longint'(zone), longint'(vgain));
    res.ref_one   = REF_W'(ref_one);
    res.ref_two   = REF_W'(ref_two);
    pending_drives.push_back(res);
  endtask

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      failures++;
    end
  endtask

  // register writes, predictions and comparisons, all on the rising edge
  always @(posedge clk) begin
    servo_result_t want;
    if (rst) begin
      kp    = GAIN_P_RST;
      ki    = GAIN_I_RST;
      kd    = GAIN_D_RST;
      limit = REF_LIMIT_RST;
      zone  = DEAD_ZONE_RST;
      vgain = OUTPUT_GAIN_RST;
      for (int m = 0; m < 2; m++) begin
        last_ref[m] = 0;
        cmd[m]      = 0;
        err_d1[m]   = 0;
        err_d2[m]   = 0;
      end
      pending_drives.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_GAIN_P:      kp    = cfg_wdata;
          REG_GAIN_I:      ki    = cfg_wdata;
          REG_GAIN_D:      kd    = cfg_wdata;
          REG_REF_LIMIT:   limit = cfg_wdata[LIMIT_W-1:0];
          REG_DEAD_ZONE:   zone  = cfg_wdata;
          REG_OUTPUT_GAIN: vgain = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_drives(s_tdata);
      if (m_tvalid && m_tready) begin
        if (pending_drives.size() == 0) begin
          $error("result transaction with no prediction waiting");
          failures++;
        end else begin
          want = pending_drives.pop_front();
          check_field("motor1_drive", longint'(want.drive_one),
                      longint'($signed(m_tdata[DRIVE_W-1:0])));
          check_field("motor2_drive", longint'(want.drive_two),
                      longint'($signed(m_tdata[DRIVE2_LSB+DRIVE_W-1:DRIVE2_LSB])));
          check_field("motor1_reference", longint'(want.ref_one),
                      longint'($signed(m_tdata[REF1_LSB+REF_W-1:REF1_LSB])));
          check_field("motor2_reference", longint'(want.ref_two),
                      longint'($signed(m_tdata[REF2_LSB+REF_W-1:REF2_LSB])));
          check_field("pad", 0, longint'(m_tdata[OUT_W-1:PAD_LSB]));
        end
      end
    end
    drives_waiting = pending_drives.size();
  end

endmodule

>>> test/antagonistic_servo_pid_controller_tb.sv
// ----------------------------------------------------------------------------
// antagonistic_servo_pid_controller_tb
// Drives control ticks into the servo controller under several register
// settings: a directed set of corner items, tracking sequences with small
// errors, random noise, and accumulator saturation runs at extreme gains.
// Both channels idle at random; the checker beside the block predicts and
// compares every result and the verdict is given at the end.
// ----------------------------------------------------------------------------
module antagonistic_servo_pid_controller_tb;
  import aspc_pkg::*;

  localparam int ANGLE_W = ANGLE_WIDTH_DEF;
  localparam int IN_W    = ((2 * ANGLE_W + 2 * POS_W + 7) / 8) * 8;

  // indexes past the register list, writes there are dropped
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam int HOLDOFF_CYCLES = 1500;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  // equilibrium_angle, stiffness_angle, motor1_position, motor2_position
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // motor1_drive, motor2_drive, motor1_reference, motor2_reference, zero pad
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int failures;
  int drives_waiting;
  int holdoffs_asked = 0;
  int holdoffs_done  = 0;
  int burst_left     = 8;

  // rough reference of the last item, used to build tracking positions
  int limit_now = REF_LIMIT_RST;
  int last_ref_one = 0;
  int last_ref_two = 0;

  antagonistic_servo_pid_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  antagonistic_servo_pid_controller_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tdata        (s_tdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .m_tdata        (m_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .failures       (failures),
    .drives_waiting (drives_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int any_word();
    logic signed [15:0] w;
    w = $urandom;
    return w;
  endfunction

  function automatic int fit_position(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int ref_guess(int raw);
    int t;
    t = raw * 100 / 157;
    if (t > limit_now) t = limit_now;
    if (t < -limit_now) t = -limit_now;
    return 2 * t;
  endfunction

  // one input transaction, then a random gap at the end of a burst
  task automatic send_item(input int eq, input int st, input int p1, input int p2);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {16'(p2), 16'(p1), 16'(st), 16'(eq)};
    do @(posedge clk); while (!s_tready);
    last_ref_one = ref_guess(eq + st);
    last_ref_two = ref_guess(eq - st);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 220);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // mostly tracking sequences, some noise and extremes
  task automatic random_item();
    int kind, eq, st, p1, p2, spread;
    kind = $urandom_range(0, 9);
    eq = $urandom_range(0, 1) ? any_word() : int'($urandom_range(0, 8191)) - 4096;
    st = $urandom_range(0, 1) ? any_word() : int'($urandom_range(0, 8191)) - 4096;
    case ($urandom_range(0, 2))
      0:       spread = 3;
      1:       spread = 64;
      default: spread = 2048;
    endcase
    if (kind < 6) begin
      p1 = fit_position(last_ref_one + int'($urandom_range(0, 2 * spread)) - spread);
      p2 = fit_position(last_ref_two + int'($urandom_range(0, 2 * spread)) - spread);
    end else if (kind < 8) begin
      p1 = any_word();
      p2 = any_word();
    end else begin
      p1 = $urandom_range(0, 1) ? 32767 : -32768;
      p2 = $urandom_range(0, 1) ? 32767 : -32768;
      if (kind == 9) begin
        eq = $urandom_range(0, 1) ? 32767 : -32768;
        st = $urandom_range(0, 1) ? 32767 : -32768;
      end
    end
    send_item(eq, st, p1, p2);
  endtask

  // sender pause until every result is back
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (drives_waiting != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_REF_LIMIT) limit_now = value & 32'h7FFF;
  endtask

  // new random settings on an idle block, then random items
  task automatic random_phase(input int items);
    drain_results();
    write_reg(REG_GAIN_P, $urandom_range(0, 1) ? $urandom_range(0, 2047) : $urandom_range(0, 65535));
    write_reg(REG_GAIN_I, $urandom_range(0, 1) ? 0 : $urandom_range(0, 63));
    write_reg(REG_GAIN_D, $urandom_range(0, 4095));
    write_reg(REG_REF_LIMIT, $urandom_range(0, 32767));
    write_reg(REG_DEAD_ZONE, $urandom_range(0, 40000));
    write_reg(REG_OUTPUT_GAIN, $urandom_range(0, 65535));
    repeat (items) random_item();
  endtask

  // result side stalls, with one long hold-off on request
  initial begin : result_sink
    int mode, span, tick;
    tick = 0;
    forever begin
      if (holdoffs_done != holdoffs_asked) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoffs_done++;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 400);
        repeat (span) begin
          @(negedge clk);
          tick++;
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            2:       m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ((tick % 7) < 3);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int sign;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: corners of the fields
    send_item(0, 0, 0, 0);
    send_item(32767, 32767, 32767, 32767);
    send_item(-32768, -32768, -32768, -32768);
    send_item(-32768, 32767, 0, 0);
    send_item(32767, -32768, -32768, 32767);
    send_item(1, 0, 0, 0);
    send_item(-1, 0, 0, 0);
    // zero error on both motors, then errors inside the dead zone
    send_item(157, 0, last_ref_one, last_ref_two);
    send_item(157, 0, last_ref_one, last_ref_two);
    send_item(157, 0, last_ref_one, last_ref_two);
    send_item(157, 0, last_ref_one + 5, last_ref_two - 5);
    send_item(-314, 157, last_ref_one - 3, last_ref_two + 3);
    send_item(0, 0, 32767, -32768);
    send_item(0, 0, -32768, 32767);
    send_item(0, 0, 0, 0);
    repeat (100) random_item();

    // everything zero, plus writes past the register list
    drain_results();
    write_reg(REG_GAIN_P, 0);
    write_reg(REG_GAIN_I, 0);
    write_reg(REG_GAIN_D, 0);
    write_reg(REG_REF_LIMIT, 0);
    write_reg(REG_DEAD_ZONE, 0);
    write_reg(REG_OUTPUT_GAIN, 0);
    write_reg(REG_UNUSED_LO, $urandom_range(0, 65535));
    write_reg(REG_UNUSED_HI, $urandom_range(0, 65535));
    repeat (30) random_item();

    // widest dead zone
    drain_results();
    write_reg(REG_GAIN_P, $urandom_range(0, 4095));
    write_reg(REG_GAIN_D, $urandom_range(0, 4095));
    write_reg(REG_REF_LIMIT, 16434);
    write_reg(REG_DEAD_ZONE, 65535);
    write_reg(REG_OUTPUT_GAIN, 65535);
    repeat (50) random_item();

    // random settings; a long output hold-off while items keep coming
    random_phase(10);
    holdoffs_asked++;
    repeat (60) random_item();
    random_phase(35);
    drain_results();
    repeat (35) random_item();
    random_phase(70);
    random_phase(70);

    // extreme gains and limits, saturating both accumulators each way
    drain_results();
    write_reg(REG_GAIN_P, 65535);
    write_reg(REG_GAIN_I, 65535);
    write_reg(REG_GAIN_D, 65535);
    write_reg(REG_REF_LIMIT, 65535);
    write_reg(REG_DEAD_ZONE, 0);
    write_reg(REG_OUTPUT_GAIN, 65535);
    repeat (160) begin
      sign = $urandom_range(0, 1);
      send_item(32767, sign ? 32767 : -32767,
                -32768 + int'($urandom_range(0, 255)), -32768 + int'($urandom_range(0, 255)));
    end
    repeat (160) begin
      sign = $urandom_range(0, 1);
      send_item(-32768, sign ? 32767 : -32768,
                32767 - int'($urandom_range(0, 255)), 32767 - int'($urandom_range(0, 255)));
    end
    repeat (30) random_item();

    drain_results();
    repeat (400) @(negedge clk);
    if (failures == 0) begin
      $display("antagonistic_servo_pid_controller_tb passed");
    end else begin
      $display("antagonistic_servo_pid_controller_tb failed");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #10000000;
    $display("antagonistic_servo_pid_controller_tb failed");
    $finish;
  end

endmodule
